// File: src/ffra_pkg.sv
// Shared constants and types for the first-fit range allocator.
package ffra_pkg;

  localparam int unsigned RegionSlotsDefault = 256;
  // page size in bytes, a power of two so that rounding is a mask
  localparam int unsigned PageBytesDefault   = 4096;

  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 33;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NO_SLOT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_HEAP_BASE = 1'b0,
    CFG_HEAP_LAST = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_FILL,
    S_INIT_HEAD,
    S_WALK_RD,
    S_WALK_CHK,
    S_ALLOC_UNLINK,
    S_SPARE_RD,
    S_SPARE_CHK,
    S_DONE
  } state_e;

endpackage

// File: src/ffra_mem.sv
// Region slot memory: start, length and link per slot, one write and one read port.
module ffra_mem import ffra_pkg::*; #(
  parameter int unsigned RegionSlots = RegionSlotsDefault,
  parameter int unsigned IdxW        = $clog2(RegionSlots)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  logic [AddrW-1:0] wstart_i,
  input  logic [LenW-1:0]  wlen_i,
  input  logic [IdxW:0]    wlink_i,
  input  logic [IdxW-1:0]  raddr_i,
  output logic [AddrW-1:0] rstart_o,
  output logic [LenW-1:0]  rlen_o,
  output logic [IdxW:0]    rlink_o
);

  logic [AddrW-1:0] start_mem [RegionSlots];
  logic [LenW-1:0]  len_mem   [RegionSlots];
  logic [IdxW:0]    link_mem  [RegionSlots];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      start_mem[waddr_i] <= wstart_i;
      len_mem[waddr_i]   <= wlen_i;
      link_mem[waddr_i]  <= wlink_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rstart_o <= start_mem[raddr_i];
    rlen_o   <= len_mem[raddr_i];
    rlink_o  <= link_mem[raddr_i];
  end

endmodule

// File: src/first_fit_range_allocator.sv
// Top level of the first-fit range allocator: sequencer around the slot memory.
//
// Usage: raise start with action_i, req_size_i and free_addr_i while busy
// is low; the transaction is taken at that edge and busy rises unless it
// needs no work (see below). When the work is done, done_o is high for one
// cycle with result_addr_o, status_o and slots_used_o; busy is low in that
// cycle. The receiver cannot stall. Configuration: cfg_we_i, cfg_idx_i
// (0 heap_base, 1 heap_last), cfg_wdata_i, written while idle.
// One slot memory with one read and one write port. Init chains one slot
// per cycle; allocate walks the regions in list order, with an extra unlink
// step when an emptied region is unlinked behind another. Overflow, an
// unused action, an allocation from an empty list or a free with no spare
// slot need no work: busy stays low and the result follows the start.
// One transaction at a time; the next one can be taken in the cycle that
// shows done_o. Reset empties region list and spare stack; the slot memory
// itself is not cleared: init chains it.
module first_fit_range_allocator import ffra_pkg::*; #(
  parameter int unsigned RegionSlots = RegionSlotsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [31:0]      req_size_i,
  input  logic [31:0]      free_addr_i,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i,
  output logic             done_o,
  output logic [31:0]      result_addr_o,
  output logic [1:0]       status_o,
  output logic [8:0]       slots_used_o
);

  localparam int unsigned IdxW   = $clog2(RegionSlots);
  localparam int unsigned CntW   = IdxW + 1;
  localparam logic [CntW-1:0] NullLink = CntW'(RegionSlots);
  localparam logic [CntW-1:0] LastSlot = CntW'(RegionSlots - 1);
  localparam logic [33:0] PageM1 = 34'(PageBytesDefault - 1);

  // configuration registers
  logic [31:0] heap_base_q, heap_last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      heap_last_q <= 32'd4095;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HEAP_BASE: heap_base_q <= cfg_wdata_i;
        CFG_HEAP_LAST: heap_last_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // size rounding up to a page: add page-1, then mask the low bits
  logic [33:0] sum_w, rnd_w;
  always_comb begin
    sum_w = {2'b00, req_size_i} + PageM1;
    rnd_w = sum_w & ~PageM1;
  end

  state_e state_q, state_d;
  action_e act_q, act_d;
  logic [LenW-1:0]  size_q, size_d;
  logic [31:0]      faddr_q, faddr_d;
  logic [CntW-1:0]  cur_q, cur_d, prev_q, prev_d;
  logic [CntW-1:0]  head_q, head_d, spare_q, spare_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  nxt_q, nxt_d;
  logic [31:0]      addr_q, addr_d;
  status_e          st_q, st_d;
  logic             done_q, done_d;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [AddrW-1:0] wstart, rstart;
  logic [LenW-1:0]  wlen, rlen;
  logic [CntW-1:0]  wlink, rlink;

  ffra_mem #(.RegionSlots(RegionSlots), .IdxW(IdxW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wstart_i(wstart), .wlen_i(wlen),
    .wlink_i(wlink), .raddr_i(raddr), .rstart_o(rstart), .rlen_o(rlen),
    .rlink_o(rlink)
  );

  function automatic logic ok(input logic [CntW-1:0] s);
    return s < NullLink;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NullLink;
      spare_q <= NullLink;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      spare_q <= spare_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    size_q  <= size_d;
    faddr_q <= faddr_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    cnt_q   <= cnt_d;
    nxt_q   <= nxt_d;
    addr_q  <= addr_d;
    st_q    <= st_d;
  end

  // sequencer
  always_comb begin
    logic [LenW-1:0] rem;
    state_d = state_q; act_d = act_q; size_d = size_q; faddr_d = faddr_q;
    cur_d = cur_q; prev_d = prev_q; head_d = head_q; spare_d = spare_q;
    used_d = used_q; cnt_d = cnt_q; nxt_d = nxt_q; addr_d = addr_q; st_d = st_q;
    done_d = 1'b0;
    we = 1'b0; waddr = cur_q[IdxW-1:0]; wstart = rstart; wlen = rlen;
    wlink = rlink; raddr = cur_q[IdxW-1:0];
    rem = rlen - size_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          act_d = action_e'(action_i); size_d = rnd_w[LenW-1:0];
          faddr_d = free_addr_i; addr_d = '0; st_d = ST_OK;
          cnt_d = '0; cur_d = head_q; prev_d = NullLink;
          raddr = head_q[IdxW-1:0];
          case (action_e'(action_i))
            ACT_INIT: state_d = S_INIT_FILL;
            ACT_ALLOC, ACT_FREE: begin
              if (rnd_w[33:32] != 2'b00) begin
                st_d = ST_OVERFLOW; done_d = 1'b1;
              end else if (action_e'(action_i) == ACT_ALLOC) begin
                if (ok(head_q)) state_d = S_WALK_CHK;
                else begin st_d = ST_NO_SPACE; done_d = 1'b1; end
              end else begin
                if (ok(spare_q)) begin
                  cur_d = spare_q; state_d = S_SPARE_RD;
                end else begin st_d = ST_NO_SLOT; done_d = 1'b1; end
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      // chain slot cnt to cnt+1, slot 0 becomes the heap region
      S_INIT_FILL: begin
        we = 1'b1; waddr = cnt_q[IdxW-1:0];
        wstart = '0; wlen = '0;
        wlink = (cnt_q == LastSlot) ? NullLink : cnt_q + 1'b1;
        if (cnt_q == '0) begin
          wstart = heap_base_q;
          wlen = {1'b0, heap_last_q - heap_base_q} + 33'd1;
          wlink = NullLink;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastSlot) state_d = S_INIT_HEAD;
      end
      S_INIT_HEAD: begin
        head_d = '0; used_d = CntW'(1);
        spare_d = (RegionSlots > 1) ? CntW'(1) : NullLink;
        done_d = 1'b1; state_d = S_IDLE;
      end
      S_WALK_RD: state_d = S_WALK_CHK;
      S_WALK_CHK: begin
        if (rlen >= size_q) begin
          addr_d = rstart;
          we = 1'b1; wstart = rstart + size_q[31:0]; wlen = rem;
          if (rem == '0) begin
            wstart = '0; wlink = spare_q;
            spare_d = cur_q; used_d = used_q - 1'b1;
            if (ok(prev_q)) begin
              nxt_d = rlink; raddr = prev_q[IdxW-1:0];
              state_d = S_ALLOC_UNLINK;
            end else begin
              head_d = rlink; done_d = 1'b1; state_d = S_IDLE;
            end
          end else begin
            done_d = 1'b1; state_d = S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
          if (!ok(rlink) || cnt_q == LastSlot) begin
            st_d = ST_NO_SPACE; done_d = 1'b1; state_d = S_IDLE;
          end else begin
            prev_d = cur_q; cur_d = rlink; raddr = rlink[IdxW-1:0];
            state_d = S_WALK_RD;
          end
        end
      end
      // keep the previous region on the read port for the relink write
      S_ALLOC_UNLINK: begin
        raddr = prev_q[IdxW-1:0];
        state_d = S_SPARE_CHK;
      end
      S_SPARE_RD: state_d = S_SPARE_CHK;
      S_SPARE_CHK: begin
        we = 1'b1;
        if (act_q == ACT_ALLOC) begin
          waddr = prev_q[IdxW-1:0]; wlink = nxt_q;
        end else begin
          spare_d = rlink; used_d = used_q + 1'b1;
          wstart = faddr_q; wlen = size_q; wlink = head_q; head_d = cur_q;
        end
        done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (done_d) state_d = S_IDLE;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign result_addr_o = (act_q == ACT_ALLOC && st_q == ST_OK) ? addr_q : '0;
  assign status_o      = st_q;
  assign slots_used_o  = 9'(used_q);

endmodule

// File: src/ffra_checker.sv
// Port-level checker for the first-fit range allocator, bound to the top level.
module ffra_checker import ffra_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] result_addr_o,
  input logic [1:0]  status_o
);

  // a result closes the transaction: busy is low with it
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");

  // a failed status never carries an address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> result_addr_o == 32'd0)
    else $error("address on failure");

  // no result without start or work going on in the previous cycle
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || $past(start))
    else $error("spurious result");

  // results are single-cycle strobes
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o || $past(start))
    else $error("result repeated");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .result_addr_o, .status_o
);

// File: tb/sv/testbench.sv
// Self-checking testbench for the first-fit range allocator: directed and random transactions.
`timescale 1ns / 1ps

module testbench;
  import ffra_pkg::*;

  localparam int unsigned Slots     = 256;
  localparam int unsigned PageSz    = 4096;
  localparam logic [8:0]  NoLink    = 9'(Slots);
  localparam int unsigned StallMax  = 20000;

  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
    logic [8:0]  used;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = '0;
  logic [31:0] req_size_i = '0;
  logic [31:0] free_addr_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [31:0] result_addr_o;
  logic [1:0]  status_o;
  logic [8:0]  slots_used_o;

  first_fit_range_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .req_size_i, .free_addr_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .result_addr_o, .status_o,
    .slots_used_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the allocator state
  logic [31:0] heap_base_q, heap_last_q;
  logic [31:0] rg_base [Slots];
  logic [32:0] rg_len  [Slots];
  logic [8:0]  rg_next [Slots];
  logic [8:0]  free_list_head, spare_top, used_slots;

  alloc_result_t pending_results[$];
  int unsigned   mismatches;
  int unsigned   idle_pct;
  int unsigned   stall_cycles = 0;

  function automatic logic [8:0] pop_spare();
    logic [8:0] s;
    s = spare_top;
    if (s >= NoLink) return NoLink;
    spare_top  = rg_next[s];
    used_slots = used_slots + 9'd1;
    rg_base[s] = '0;
    rg_len[s]  = '0;
    rg_next[s] = NoLink;
    return s;
  endfunction

  function automatic alloc_result_t compute_result(action_e act, logic [31:0] sz,
                                                   logic [31:0] faddr);
    alloc_result_t     res;
    longint unsigned   rounded;
    logic [8:0]        cur, prev, s;
    res = '{addr: '0, status: ST_OK, used: '0};
    rounded = ((longint'(sz) + PageSz - 1) / PageSz) * PageSz;
    if (act == ACT_INIT) begin
      for (int i = 0; i < Slots; i++) rg_next[i] = 9'(i + 1);
      rg_next[Slots-1] = NoLink;
      spare_top = '0;
      used_slots = '0;
      free_list_head = NoLink;
      s = pop_spare();
      rg_base[s] = heap_base_q;
      rg_len[s]  = {1'b0, heap_last_q - heap_base_q} + 33'd1;
      rg_next[s] = NoLink;
      free_list_head = s;
    end else if (act == ACT_ALLOC || act == ACT_FREE) begin
      if (rounded > 64'hFFFF_FFFF) begin
        res.status = ST_OVERFLOW;
      end else if (act == ACT_ALLOC) begin
        // first fit walk, trimming from the front
        res.status = ST_NO_SPACE;
        cur = free_list_head;
        prev = NoLink;
        for (int n = 0; n < Slots && cur < NoLink; n++) begin
          if (rg_len[cur] >= 33'(rounded)) begin
            res.addr   = rg_base[cur];
            res.status = ST_OK;
            rg_base[cur] = rg_base[cur] + 32'(rounded);
            rg_len[cur]  = rg_len[cur] - 33'(rounded);
            if (rg_len[cur] == '0) begin
              if (prev < NoLink) rg_next[prev] = rg_next[cur];
              else free_list_head = rg_next[cur];
              rg_base[cur] = '0;
              rg_next[cur] = spare_top;
              spare_top = cur;
              if (used_slots > 0) used_slots = used_slots - 9'd1;
            end
            break;
          end
          prev = cur;
          cur = rg_next[cur];
        end
      end else begin
        s = pop_spare();
        if (s >= NoLink) begin
          res.status = ST_NO_SLOT;
        end else begin
          rg_base[s] = faddr;
          rg_len[s]  = 33'(rounded);
          rg_next[s] = free_list_head;
          free_list_head = s;
        end
      end
    end
    if (act != ACT_ALLOC || res.status != ST_OK) res.addr = '0;
    res.used = used_slots;
    return res;
  endfunction

  // Result checker: every done strobe is one transaction
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result addr=%h status=%0d used=%0d",
                   result_addr_o, status_o, slots_used_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (result_addr_o !== exp_r.addr || status_o !== exp_r.status ||
            slots_used_o !== exp_r.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp addr=%h status=%0d used=%0d, got addr=%h status=%0d used=%0d",
                     exp_r.addr, exp_r.status, exp_r.used,
                     result_addr_o, status_o, slots_used_o);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallMax) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge with start low
  task automatic send_op(action_e act, logic [31:0] sz, logic [31:0] faddr);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start = 1'b1;
    action_i = act;
    req_size_i = sz;
    free_addr_i = faddr;
    // busy is stable at the falling edge; the next rising edge accepts
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(compute_result(act, sz, faddr));
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    if (idx == CFG_HEAP_BASE) heap_base_q = val;
    else heap_last_q = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_heap(logic [31:0] base, logic [31:0] last);
    wait_drained();
    write_reg(CFG_HEAP_BASE, base);
    write_reg(CFG_HEAP_LAST, last);
  endtask

  // Before any init: empty list and empty spare stack
  task automatic test_before_init();
    send_op(ACT_FREE, 32'd100, 32'h1234_0000);
    send_op(ACT_ALLOC, 32'd0, '0);
    send_op(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(ACT_ALLOC, 32'hFFFF_FFFF, '0);
  endtask

  task automatic test_directed();
    // default heap of one page
    send_op(ACT_INIT, '0, '0);
    send_op(ACT_ALLOC, 32'd0, '0);
    send_op(ACT_ALLOC, 32'd1, '0);
    send_op(ACT_ALLOC, 32'd1, '0);
    send_op(ACT_FREE, 32'd0, 32'hFFFF_FFFF);
    send_op(ACT_ALLOC, 32'd0, '0);
    send_op(ACT_FREE, 32'hFFFF_F000, 32'h0000_1000);
    send_op(ACT_FREE, 32'hFFFF_F001, '0);
    send_op(ACT_ALLOC, 32'hFFFF_F000, '0);
    send_op(ACT_NOP, '0, '0);
    // whole 32-bit space, then inverted bounds that wrap the address
    set_heap(32'h0000_0000, 32'hFFFF_FFFF);
    send_op(ACT_INIT, '0, '0);
    send_op(ACT_ALLOC, 32'hFFFF_F000, '0);
    send_op(ACT_ALLOC, 32'd4096, '0);
    send_op(ACT_ALLOC, 32'd1, '0);
    set_heap(32'hFFFF_F000, 32'h0000_1FFF);
    send_op(ACT_INIT, '0, '0);
    send_op(ACT_ALLOC, 32'd8192, '0);
    send_op(ACT_INIT, '0, '0);
    send_op(ACT_ALLOC, 32'd4096, '0);
    send_op(ACT_ALLOC, 32'd8192, '0);
    send_op(ACT_ALLOC, 32'd8192, '0);
    // equal bounds: a one-byte heap
    set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(ACT_INIT, '0, '0);
    send_op(ACT_ALLOC, 32'd1, '0);
  endtask

  // Fill every slot with freed regions, then allocate from them
  task automatic test_slot_exhaustion();
    set_heap(32'h0010_0000, 32'h0010_3FFF);
    send_op(ACT_INIT, '0, '0);
    for (int i = 0; i < Slots + 2; i++)
      send_op(ACT_FREE, 32'($urandom_range(1, 2) * PageSz), $urandom());
    for (int i = 0; i < 40; i++)
      send_op(ACT_ALLOC, 32'($urandom_range(0, 3) * PageSz), '0);
  endtask

  task automatic random_phase(int unsigned n_ops);
    logic [31:0] base, sz;
    int unsigned roll;
    case ($urandom_range(3))
      0: base = '0;
      1: base = 32'hFFFF_0000 + 32'($urandom_range(15) * PageSz);
      default: base = $urandom();
    endcase
    set_heap(base, base + 32'($urandom_range(1, 48) * PageSz) - 32'($urandom_range(1, 2)));
    send_op(ACT_INIT, '0, '0);
    for (int unsigned k = 0; k < n_ops; k++) begin
      roll = $urandom_range(99);
      if ($urandom_range(3) == 0) sz = 32'($urandom_range(0, 5) * PageSz);
      else sz = 32'($urandom_range(0, 6 * PageSz));
      if (roll < 52)      send_op(ACT_ALLOC, sz, $urandom());
      else if (roll < 84) send_op(ACT_FREE, sz, $urandom());
      else if (roll < 90) send_op(roll[0] ? ACT_ALLOC : ACT_FREE, $urandom(), $urandom());
      else if (roll < 94) send_op(ACT_ALLOC, $urandom() | 32'hFFFF_F001, '0);
      else if (roll < 97) send_op(ACT_INIT, $urandom(), $urandom());
      else                send_op(ACT_NOP, $urandom(), $urandom());
    end
  endtask

  task automatic test_random();
    int unsigned modes [3] = '{36, 54, 0};
    foreach (modes[m]) begin
      idle_pct = modes[m];
      for (int p = 0; p < 3; p++) random_phase(112);
      // hold off until every result is back
      wait_drained();
    end
  endtask

  initial begin
    heap_base_q = '0;
    heap_last_q = 32'd4095;
    free_list_head = NoLink;
    spare_top = NoLink;
    used_slots = '0;
    mismatches = 0;
    idle_pct = 0;
    foreach (rg_base[i]) begin
      rg_base[i] = '0;
      rg_len[i] = '0;
      rg_next[i] = '0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_pct = 36;
    test_before_init();
    test_directed();
    test_slot_exhaustion();
    test_random();

    wait_drained();
    repeat (600) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
